// File: rtl/core/pnff_pkg.sv
// pnff_pkg: shared widths, codes and stage structs of the next-frame pixel filter
// no dependencies; imported by every module in rtl/core but pnff_ram

package pnff_pkg;

    localparam int POS_W        = 12;
    localparam int VAL_W        = 16;
    localparam int GAIN_W       = 32;
    localparam int OFS_W        = 48;
    localparam int CAL_W        = GAIN_W + OFS_W;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int FRAME_PIXELS_DEF = 4096;

    localparam logic [OFS_W-1:0] ENERGY_MAX = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic [OFS_W-1:0] ENERGY_MIN = {1'b1, {(OFS_W-1){1'b0}}};

    // input item kind
    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_LOAD  = 1'b1
    } t_mode;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THR_SEL    = 8'd0,
        REG_GLOBAL_THR = 8'd1,
        REG_REORDER_EN = 8'd2,
        REG_ENERGY_EN  = 8'd3
    } t_cfg_reg;

    typedef struct packed {
        logic             thr_sel;
        logic [VAL_W-1:0] global_thr;
        logic             reorder_en;
        logic             energy_en;
    } t_cfg;

    // item leaving the lookup stage (position resolved)
    typedef struct packed {
        logic              load;
        logic [POS_W-1:0]  pos;
        logic              in_frame;
        logic [VAL_W-1:0]  pval;
        logic [VAL_W-1:0]  pthr;
        logic [GAIN_W-1:0] gain;
        logic [OFS_W-1:0]  ofs;
        logic              last;
    } t_lookup_item;

    // pixel held while its store and table reads return
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             in_frame;
        logic [VAL_W-1:0] pval;
        logic [VAL_W-1:0] pthr;
        logic             last;
    } t_filter_item;

    // filtered pixel with product, ready for offset and saturation
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] outv;
        logic             evalid;
        logic [OFS_W-1:0] prod;
        logic [OFS_W-1:0] ofs;
        logic             last;
    } t_calc_item;

endpackage

// File: rtl/core/pnff_ram.sv
// pnff_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module pnff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pnff_lookup.sv
// pnff_lookup: input register and position map, resolves the output position
// depends on pnff_pkg and pnff_ram

module pnff_lookup
    import pnff_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_clearing,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_mode,
    input  logic [VAL_W-1:0]         i_pixel_value,
    input  logic [VAL_W-1:0]         i_pixel_threshold,
    input  logic [POS_W-1:0]         i_raw_position,
    input  logic [POS_W-1:0]         i_map_target,
    input  logic [GAIN_W-1:0]        i_gradient_in,
    input  logic [OFS_W-1:0]         i_intercept_in,
    input  logic                     i_frame_last,
    // toward the filter stage
    input  logic                     i_take,
    output logic                     o_valid,
    output t_lookup_item             o_item
);

    localparam int AW = $clog2(FRAME_PIXELS);

    logic               r_valid;
    logic               r_load;
    logic [POS_W-1:0]   r_rpos;
    logic               r_rpos_in;
    logic [VAL_W-1:0]   r_pval;
    logic [VAL_W-1:0]   r_pthr;
    logic [GAIN_W-1:0]  r_gain;
    logic [OFS_W-1:0]   r_ofs;
    logic               r_last;

    logic               accept;
    logic               in_load;
    logic               in_inside;
    logic [POS_W+AW-1:0] in_ext;
    logic [AW-1:0]      in_addr;
    logic [POS_W-1:0]   map_q;
    logic [POS_W-1:0]   pos;

    // input transfer when the stage is empty or moving on
    assign o_stall = i_clearing || (r_valid && !i_take);
    assign accept  = i_valid && !o_stall;
    assign in_load = (t_mode'(i_mode) == MODE_LOAD);

    // raw position as map address
    assign in_inside = (32'(i_raw_position) < 32'(FRAME_PIXELS));
    assign in_ext    = {{AW{1'b0}}, i_raw_position};
    assign in_addr   = in_ext[AW-1:0];

    // map is written and read in transfer order at the input
    pnff_ram #(
        .WIDTH (POS_W),
        .DEPTH (FRAME_PIXELS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (accept && in_load && in_inside),
        .i_waddr (in_addr),
        .i_wdata (i_map_target),
        .i_re    (accept && !in_load),
        .i_raddr (in_addr),
        .o_rdata (map_q)
    );

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_take) begin
            r_valid <= accept;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_load    <= in_load;
            r_rpos    <= i_raw_position;
            r_rpos_in <= in_inside;
            r_pval    <= i_pixel_value;
            r_pthr    <= i_pixel_threshold;
            r_gain    <= i_gradient_in;
            r_ofs     <= i_intercept_in;
            r_last    <= i_frame_last;
        end
    end

    // output position: loads keep the table address
    always_comb begin
        if (!r_load && i_cfg.reorder_en) begin
            pos = r_rpos_in ? map_q : '0;
        end else begin
            pos = r_rpos;
        end
    end

    assign o_valid         = r_valid;
    assign o_item.load     = r_load;
    assign o_item.pos      = pos;
    assign o_item.in_frame = (32'(pos) < 32'(FRAME_PIXELS));
    assign o_item.pval     = r_pval;
    assign o_item.pthr     = r_pthr;
    assign o_item.gain     = r_gain;
    assign o_item.ofs      = r_ofs;
    assign o_item.last     = r_last;

endmodule

// File: rtl/core/pnff_filter.sv
// pnff_filter: previous-frame store with write-through, calibration tables,
// threshold test and gain product; clears the store after reset
// depends on pnff_pkg and pnff_ram

module pnff_filter
    import pnff_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    output logic         o_clearing,
    // from lookup stage
    input  logic         i_valid,
    input  t_lookup_item i_item,
    output logic         o_take,
    // toward energy stage
    input  logic         i_take,
    output logic         o_valid,
    output t_calc_item   o_item
);

    localparam int AW = $clog2(FRAME_PIXELS);

    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_addr;

    logic                r_b_valid;
    t_filter_item        r_b;
    logic                r_byp;
    logic [VAL_W-1:0]    r_byp_data;

    logic                r_c_valid;
    t_calc_item          r_c;

    logic                b_move;
    logic                b_free;
    logic                a_move;
    logic [POS_W+AW-1:0] a_ext;
    logic [AW-1:0]       a_addr;
    logic [POS_W+AW-1:0] b_ext;
    logic [AW-1:0]       b_addr;

    logic                prev_we;
    logic [AW-1:0]       prev_waddr;
    logic [VAL_W-1:0]    prev_wdata;
    logic [VAL_W-1:0]    prev_q;
    logic [CAL_W-1:0]    cal_q;

    logic [VAL_W-1:0]    prev;
    logic [VAL_W-1:0]    thr;
    logic                pass;
    logic [VAL_W-1:0]    outv;
    logic signed [VAL_W:0]    pv_s;
    logic signed [GAIN_W-1:0] g_s;
    logic signed [OFS_W-1:0]  prod;
    logic [OFS_W-1:0]    ofs;

    // stage handshake
    assign b_move = r_b_valid && (!r_c_valid || i_take);
    assign b_free = !r_b_valid || b_move;
    assign a_move = i_valid && b_free;
    assign o_take = b_free;

    assign a_ext  = {{AW{1'b0}}, i_item.pos};
    assign a_addr = a_ext[AW-1:0];
    assign b_ext  = {{AW{1'b0}}, r_b.pos};
    assign b_addr = b_ext[AW-1:0];

    // clearing pass over the whole store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(FRAME_PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_clearing = r_clr_busy;

    // store write port: clearing sweep or write-through of the pixel leaving
    always_comb begin
        if (r_clr_busy) begin
            prev_we    = 1'b1;
            prev_waddr = r_clr_addr;
            prev_wdata = '0;
        end else begin
            prev_we    = b_move && r_b.in_frame;
            prev_waddr = b_addr;
            prev_wdata = outv;
        end
    end

    pnff_ram #(
        .WIDTH (VAL_W),
        .DEPTH (FRAME_PIXELS)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (a_move && !i_item.load),
        .i_raddr (a_addr),
        .o_rdata (prev_q)
    );

    // gain and offset share one entry
    pnff_ram #(
        .WIDTH (CAL_W),
        .DEPTH (FRAME_PIXELS)
    ) u_cal_ram (
        .i_clk   (i_clk),
        .i_we    (a_move && i_item.load && i_item.in_frame),
        .i_waddr (a_addr),
        .i_wdata ({i_item.gain, i_item.ofs}),
        .i_re    (a_move && !i_item.load),
        .i_raddr (a_addr),
        .o_rdata (cal_q)
    );

    // read stage: loads end here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= a_move && !i_item.load;
        end
    end

    // payload plus forwarding of a same-position write in the read cycle
    always_ff @(posedge i_clk) begin
        if (a_move && !i_item.load) begin
            r_b.pos      <= i_item.pos;
            r_b.in_frame <= i_item.in_frame;
            r_b.pval     <= i_item.pval;
            r_b.pthr     <= i_item.pthr;
            r_b.last     <= i_item.last;
            r_byp        <= prev_we && (prev_waddr == a_addr);
            r_byp_data   <= prev_wdata;
        end
    end

    // threshold and next-frame test
    always_comb begin
        prev = '0;
        if (r_b.in_frame) begin
            prev = r_byp ? r_byp_data : prev_q;
        end
        thr  = i_cfg.thr_sel ? r_b.pthr : i_cfg.global_thr;
        pass = (r_b.pval >= thr) && (prev == '0);
        outv = pass ? r_b.pval : '0;
    end

    // gain product, value is unsigned
    assign pv_s = {1'b0, r_b.pval};
    assign g_s  = r_b.in_frame ? $signed(cal_q[CAL_W-1:OFS_W]) : '0;
    assign prod = OFS_W'(pv_s) * OFS_W'(g_s);
    assign ofs  = r_b.in_frame ? cal_q[OFS_W-1:0] : '0;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (!r_c_valid || i_take) begin
            r_c_valid <= b_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_c.pos    <= r_b.pos;
            r_c.outv   <= outv;
            r_c.evalid <= pass && i_cfg.energy_en;
            r_c.prod   <= prod;
            r_c.ofs    <= ofs;
            r_c.last   <= r_b.last;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c;

endmodule

// File: rtl/core/pnff_energy.sv
// pnff_energy: offset add, 48-bit saturation and the output register
// depends on pnff_pkg

module pnff_energy
    import pnff_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // from filter stage
    input  logic                    i_valid,
    input  t_calc_item              i_item,
    output logic                    o_take,
    // output channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [POS_W-1:0]        o_out_position,
    output logic [VAL_W-1:0]        o_out_value,
    output logic signed [OFS_W-1:0] o_energy,
    output logic                    o_energy_valid,
    output logic                    o_frame_end
);

    logic                 r_valid;
    logic [POS_W-1:0]     r_pos;
    logic [VAL_W-1:0]     r_outv;
    logic [OFS_W-1:0]     r_energy;
    logic                 r_evalid;
    logic                 r_last;

    logic                 move;
    logic [OFS_W:0]       sum;
    logic [OFS_W-1:0]     sat;

    // output register is free when empty or being taken
    assign o_take = !r_valid || !i_stall;
    assign move   = i_valid && o_take;

    // sign-extended add and clamp
    assign sum = {i_item.prod[OFS_W-1], i_item.prod} + {i_item.ofs[OFS_W-1], i_item.ofs};

    always_comb begin
        if (sum[OFS_W] != sum[OFS_W-1]) begin
            sat = sum[OFS_W] ? ENERGY_MIN : ENERGY_MAX;
        end else begin
            sat = sum[OFS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_pos    <= i_item.pos;
            r_outv   <= i_item.outv;
            r_energy <= i_item.evalid ? sat : '0;
            r_evalid <= i_item.evalid;
            r_last   <= i_item.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_position = r_pos;
    assign o_out_value    = r_outv;
    assign o_energy       = $signed(r_energy);
    assign o_energy_valid = r_evalid;
    assign o_frame_end    = r_last;

endmodule

// File: rtl/core/pixel_next_frame_filter.sv
// pixel_next_frame_filter: top level, configuration registers and stage wiring
// depends on pnff_pkg, pnff_lookup, pnff_filter, pnff_energy
//
// Usage:
// - input channel i_valid / o_stall carries one item per transfer; mode 0 is a
//   pixel sample, mode 1 loads map, gain and offset at raw_position
// - output channel o_valid / i_stall gives one result per pixel sample and
//   none for a load
// - configuration channel i_cfg_valid / o_cfg_ready writes register
//   i_cfg_index; it is always ready; unknown indexes are ignored
// - throughput: one item per clock while o_stall is low, set by the
//   read-modify-write of the previous-frame ram; a pixel may hit the position
//   of the one before it, the store read is then forwarded from the write
// - path: input register, read stage, product stage, output register
// - reset: valid flags and configuration go to zero, then the previous-frame
//   store is swept to zero, all FRAME_PIXELS entries, while o_stall stays high
// - when the receiver stalls, results stay in place and bubbles close up;
//   input transfers go on until every stage holds an item

module pixel_next_frame_filter
    import pnff_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_mode,
    input  logic [VAL_W-1:0]         i_pixel_value,
    input  logic [VAL_W-1:0]         i_pixel_threshold,
    input  logic [POS_W-1:0]         i_raw_position,
    input  logic [POS_W-1:0]         i_map_target,
    input  logic signed [GAIN_W-1:0] i_gradient_in,
    input  logic signed [OFS_W-1:0]  i_intercept_in,
    input  logic                     i_frame_last,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [POS_W-1:0]         o_out_position,
    output logic [VAL_W-1:0]         o_out_value,
    output logic signed [OFS_W-1:0]  o_energy,
    output logic                     o_energy_valid,
    output logic                     o_frame_end,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cfg          r_cfg;
    logic          clearing;

    logic          look_valid;
    t_lookup_item  look_item;
    logic          filt_take;

    logic          calc_valid;
    t_calc_item    calc_item;
    logic          out_take;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_THR_SEL:    r_cfg.thr_sel    <= i_cfg_data[0];
                REG_GLOBAL_THR: r_cfg.global_thr <= i_cfg_data[VAL_W-1:0];
                REG_REORDER_EN: r_cfg.reorder_en <= i_cfg_data[0];
                REG_ENERGY_EN:  r_cfg.energy_en  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input register and position map
    pnff_lookup #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_lookup (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_clearing        (clearing),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_pixel_value     (i_pixel_value),
        .i_pixel_threshold (i_pixel_threshold),
        .i_raw_position    (i_raw_position),
        .i_map_target      (i_map_target),
        .i_gradient_in     (i_gradient_in),
        .i_intercept_in    (i_intercept_in),
        .i_frame_last      (i_frame_last),
        .i_take            (filt_take),
        .o_valid           (look_valid),
        .o_item            (look_item)
    );

    // previous-frame store, tables and threshold test
    pnff_filter #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .o_clearing (clearing),
        .i_valid    (look_valid),
        .i_item     (look_item),
        .o_take     (filt_take),
        .i_take     (out_take),
        .o_valid    (calc_valid),
        .o_item     (calc_item)
    );

    // offset, saturation and output register
    pnff_energy u_energy (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (calc_valid),
        .i_item         (calc_item),
        .o_take         (out_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_position (o_out_position),
        .o_out_value    (o_out_value),
        .o_energy       (o_energy),
        .o_energy_valid (o_energy_valid),
        .o_frame_end    (o_frame_end)
    );

endmodule
